// File: sv/ptk_pkg.sv
// ----------------------------------------------------------------------------
// ptk_pkg: shared types and constants of the position tracker
// Fixed-point widths, operation codes, config register indexes and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ptk_pkg;

  // filter quantities: signed, 24 fraction bits, 40 bits wide
  typedef logic signed [39:0] st_t;
  // multiplier operand: room for the sum of three filter quantities
  typedef logic signed [42:0] opnd_t;

  typedef logic [3:0] op_t;
  // micro-op order of one axis update
  localparam op_t OP_VDT    = 4'd0;
  localparam op_t OP_DTP11  = 4'd1;
  localparam op_t OP_DTSUM  = 4'd2;
  localparam op_t OP_DIV_K0 = 4'd3;
  localparam op_t OP_DIV_K1 = 4'd4;
  localparam op_t OP_K0Y    = 4'd5;
  localparam op_t OP_K1Y    = 4'd6;
  localparam op_t OP_K0P00  = 4'd7;
  localparam op_t OP_K0P01  = 4'd8;
  localparam op_t OP_K1P00  = 4'd9;
  localparam op_t OP_K1P01  = 4'd10;
  localparam op_t OP_LAST   = OP_K1P01;

  typedef logic [1:0] cfg_addr_t;
  localparam cfg_addr_t CFG_PROCESS_NOISE = 2'd0;
  localparam cfg_addr_t CFG_MEAS_NOISE    = 2'd1;
  localparam cfg_addr_t CFG_INIT_VAR      = 2'd2;

  localparam logic [31:0] PROCESS_NOISE_RST = 32'd167772;
  localparam logic [31:0] MEAS_NOISE_RST    = 32'd1677722;
  localparam logic [31:0] INIT_VAR_RST      = 32'd16777216;

  localparam logic signed [44:0] SAT_MAX = 45'sd549755813887;
  localparam logic signed [44:0] SAT_MIN = -45'sd549755813888;

  typedef struct packed {
    logic capture;
    logic load;
    logic mul_start;
    logic div_start;
    logic out_load;
    op_t  op;
  } ptk_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } ptk_sts_t;

  function automatic logic signed [44:0] ext45(input st_t x);
    return {{5{x[39]}}, x};
  endfunction

  function automatic opnd_t ext_op(input st_t x);
    return {{3{x[39]}}, x};
  endfunction

  function automatic st_t sat_st(input logic signed [44:0] x);
    st_t r;
    if (x > SAT_MAX) begin
      r = SAT_MAX[39:0];
    end else if (x < SAT_MIN) begin
      r = SAT_MIN[39:0];
    end else begin
      r = x[39:0];
    end
    return r;
  endfunction

  // Q16.24 to Q16.16, round half up, saturate to 32 bits
  function automatic logic [31:0] to_out(input st_t p);
    logic signed [40:0] r;
    logic signed [32:0] sh;
    logic [31:0]        o;
    r  = {p[39], p} + 41'sd128;
    sh = r[40:8];
    if (sh > 33'sd2147483647) begin
      o = 32'h7FFF_FFFF;
    end else if (sh < -33'sd2147483648) begin
      o = 32'h8000_0000;
    end else begin
      o = sh[31:0];
    end
    return o;
  endfunction

endpackage

// File: sv/position_kalman_tracker.sv
// ----------------------------------------------------------------------------
// position_kalman_tracker: 3-axis constant-velocity position tracker
// Independent two-state Kalman filter per axis, Q16.24 internal arithmetic.
// ----------------------------------------------------------------------------
// input beat: tdata carries three Q16.16 positions and a Q0.16 time step,
// tuser flags the measurement as valid. one output beat per input beat:
// tdata carries the three Q16.16 estimates, tuser flags the estimate valid.
// config writes (process noise, measurement noise, initial variance) are
// taken at any edge with cfg_we_i high and belong to idle periods.
// one beat is worked at a time. a tracked update runs, per axis, nine
// products on a 4-partial-product multiplier and two gains on a bit-serial
// divider; a load writes each axis in turn, and a hold goes straight to
// the output register.
// the next beat is taken as soon as the result sits in the output register,
// even while the receiver stalls; a stalled output holds the block once its
// next result is ready.
// after reset no estimate is held, so the first beat loads the filter and
// passes the measurement through.
module position_kalman_tracker #(
  parameter int AXIS_COUNT = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [111:0]       s_axis_tdata,  // meas_x, meas_y, meas_z, step_time
  input  logic               s_axis_tuser,  // sample_valid
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [95:0]        m_axis_tdata,  // est_x, est_y, est_z
  output logic               m_axis_tuser   // est_valid
);

  localparam int AXW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  ptk_pkg::ptk_cmd_t cmd;
  ptk_pkg::ptk_sts_t sts;
  logic [AXW-1:0]    axis;

  ptk_ctrl #(
    .AXIS_COUNT (AXIS_COUNT),
    .AXW        (AXW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tuser_i  (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tuser_o  (m_axis_tuser),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .axis_o     (axis)
  );

  ptk_dp #(
    .AXIS_COUNT (AXIS_COUNT),
    .AXW        (AXW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .axis_i      (axis),
    .meas_x_i    (s_axis_tdata[31:0]),
    .meas_y_i    (s_axis_tdata[63:32]),
    .meas_z_i    (s_axis_tdata[95:64]),
    .step_time_i (s_axis_tdata[111:96]),
    .sts_o       (sts),
    .est_o       (m_axis_tdata)
  );

endmodule

// File: sv/ptk_mul.sv
// ----------------------------------------------------------------------------
// ptk_mul: multi-cycle fixed-point multiplier
// Magnitude product from four 21x21 partial products, then rounding to 24
// fraction bits (half away from zero), saturation to 40 bits and sign.
// ----------------------------------------------------------------------------
module ptk_mul (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  ptk_pkg::opnd_t  a_i,
  input  ptk_pkg::opnd_t  b_i,
  output logic            done_o,
  output ptk_pkg::st_t    res_o
);

  localparam logic [60:0] MagPosLim = 61'h7F_FFFF_FFFF;
  localparam logic [60:0] MagNegLim = 61'h80_0000_0000;

  logic        busy_q;
  logic [2:0]  cnt_q;
  logic        done_q;
  logic [41:0] ma_q, mb_q;
  logic        neg_q;
  logic [83:0] acc_q;
  logic [60:0] mag_q;
  ptk_pkg::st_t res_q;

  logic [42:0] abs_a, abs_b;
  logic [20:0] hal_a, hal_b;
  logic [41:0] pp;
  logic [83:0] pp_sh;
  logic [84:0] rnd;
  logic [60:0] mlim;
  logic signed [40:0] sm;
  ptk_pkg::st_t res_d;

  always_comb begin
    abs_a = a_i[42] ? 43'(-a_i) : 43'(a_i);
    abs_b = b_i[42] ? 43'(-b_i) : 43'(b_i);
    hal_a = cnt_q[1] ? ma_q[41:21] : ma_q[20:0];
    hal_b = cnt_q[0] ? mb_q[41:21] : mb_q[20:0];
    pp    = hal_a * hal_b;
    unique case (cnt_q[1:0])
      2'b00:          pp_sh = {42'd0, pp};
      2'b01, 2'b10:   pp_sh = {21'd0, pp, 21'd0};
      default:        pp_sh = {pp, 42'd0};
    endcase
    rnd = {1'b0, acc_q} + 85'd8388608;
    if (neg_q) begin
      mlim  = (mag_q > MagNegLim) ? MagNegLim : mag_q;
      sm    = -$signed({1'b0, mlim[39:0]});
      res_d = sm[39:0];
    end else begin
      mlim  = (mag_q > MagPosLim) ? MagPosLim : mag_q;
      sm    = $signed({1'b0, mlim[39:0]});
      res_d = sm[39:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == 3'd5) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= abs_a[41:0];
      mb_q  <= abs_b[41:0];
      neg_q <= a_i[42] ^ b_i[42];
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q < 3'd4) begin
        acc_q <= acc_q + pp_sh;
      end
      if (cnt_q == 3'd4) begin
        mag_q <= rnd[84:24];
      end
      if (cnt_q == 3'd5) begin
        res_q <= res_d;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_mul_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("multiplier started while busy");
`endif

endmodule

// File: sv/ptk_div.sv
// ----------------------------------------------------------------------------
// ptk_div: gain divider
// Restoring division of num * 2^24 by a positive divisor, one quotient bit
// per cycle, truncated toward zero and saturated to 40 bits.
// ----------------------------------------------------------------------------
module ptk_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  ptk_pkg::st_t        num_i,
  input  logic signed [41:0]  den_i,
  output logic                done_o,
  output ptk_pkg::st_t        quo_o
);

  localparam logic [6:0]  IterLast = 7'd64;
  localparam logic [63:0] QPosLim  = 64'h7F_FFFF_FFFF;
  localparam logic [63:0] QNegLim  = 64'h80_0000_0000;

  logic        busy_q, done_q;
  logic [6:0]  cnt_q;
  logic [41:0] rem_q;
  logic [63:0] dq_q;
  logic [40:0] den_q;
  logic        neg_q, zero_q;
  ptk_pkg::st_t res_q;

  logic               den_pos;
  logic signed [40:0] nx, nabs;
  logic [42:0]        shl;
  logic               ge;
  logic [42:0]        diff;
  logic [63:0]        qlim;
  logic signed [40:0] sq;
  ptk_pkg::st_t       res_d;

  always_comb begin
    den_pos = den_i > 42'sd0;
    nx      = {num_i[39], num_i};
    nabs    = nx[40] ? -nx : nx;
    shl     = {rem_q, dq_q[63]};
    ge      = shl >= {2'b00, den_q};
    diff    = shl - {2'b00, den_q};
    if (neg_q) begin
      qlim  = (dq_q > QNegLim) ? QNegLim : dq_q;
      sq    = -$signed({1'b0, qlim[39:0]});
    end else begin
      qlim  = (dq_q > QPosLim) ? QPosLim : dq_q;
      sq    = $signed({1'b0, qlim[39:0]});
    end
    res_d = zero_q ? '0 : sq[39:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        // a non-positive divisor skips straight to a zero gain
        cnt_q  <= den_pos ? 7'd0 : IterLast;
      end else if (busy_q) begin
        if (cnt_q == IterLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      dq_q   <= {nabs[39:0], 24'd0};
      den_q  <= den_i[40:0];
      neg_q  <= num_i[39];
      zero_q <= !den_pos;
    end else if (busy_q) begin
      if (cnt_q != IterLast) begin
        rem_q <= ge ? diff[41:0] : shl[41:0];
        dq_q  <= {dq_q[62:0], ge};
      end else begin
        res_q <= res_d;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = res_q;

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");
`endif

endmodule

// File: sv/ptk_dp.sv
// ----------------------------------------------------------------------------
// ptk_dp: tracker datapath
// Config registers, per-axis filter state, working registers, the shared
// multiplier and divider, and the output register.
// ----------------------------------------------------------------------------
module ptk_dp #(
  parameter int AXIS_COUNT = 3,
  parameter int AXW        = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  ptk_pkg::cfg_addr_t  cfg_addr_i,
  input  logic [31:0]         cfg_wdata_i,
  input  ptk_pkg::ptk_cmd_t   cmd_i,
  input  logic [AXW-1:0]      axis_i,
  input  logic [31:0]         meas_x_i,
  input  logic [31:0]         meas_y_i,
  input  logic [31:0]         meas_z_i,
  input  logic [15:0]         step_time_i,
  output ptk_pkg::ptk_sts_t   sts_o,
  output logic [95:0]         est_o
);

  logic [31:0] pn_q, mn_q, iv_q;

  logic [31:0] meas_q [3];
  logic [23:0] dt_q;

  ptk_pkg::st_t pos_q [AXIS_COUNT];
  ptk_pkg::st_t vel_q [AXIS_COUNT];
  ptk_pkg::st_t c00_q [AXIS_COUNT];
  ptk_pkg::st_t c01_q [AXIS_COUNT];
  ptk_pkg::st_t c10_q [AXIS_COUNT];
  ptk_pkg::st_t c11_q [AXIS_COUNT];

  ptk_pkg::st_t pp_q, t_q, w00_q, w01_q, w10_q, w11_q, k0_q, k1_q;
  logic signed [40:0] y_q;
  logic [31:0] est_q [3];

  ptk_pkg::st_t cur_pos, cur_vel, cur_c00, cur_c01, cur_c10, cur_c11, z;
  ptk_pkg::opnd_t mul_a, mul_b, dt_op, y_op;
  ptk_pkg::st_t mres, qres;
  logic mul_done, div_done;
  logic signed [41:0] s_den;
  ptk_pkg::st_t div_num;
  logic signed [44:0] pn45, iv45;
  logic signed [40:0] y_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pn_q <= ptk_pkg::PROCESS_NOISE_RST;
      mn_q <= ptk_pkg::MEAS_NOISE_RST;
      iv_q <= ptk_pkg::INIT_VAR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ptk_pkg::CFG_PROCESS_NOISE: pn_q <= cfg_wdata_i;
        ptk_pkg::CFG_MEAS_NOISE:    mn_q <= cfg_wdata_i;
        ptk_pkg::CFG_INIT_VAR:      iv_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_pos = pos_q[axis_i];
    cur_vel = vel_q[axis_i];
    cur_c00 = c00_q[axis_i];
    cur_c01 = c01_q[axis_i];
    cur_c10 = c10_q[axis_i];
    cur_c11 = c11_q[axis_i];
    z       = {meas_q[axis_i], 8'd0};
    dt_op   = {19'd0, dt_q};
    y_op    = {{2{y_q[40]}}, y_q};
    pn45    = {13'd0, pn_q};
    iv45    = {13'd0, iv_q};
    y_d     = {z[39], z} - {pp_q[39], pp_q};
    s_den   = {{2{w00_q[39]}}, w00_q} + {10'd0, mn_q};
    div_num = (cmd_i.op == ptk_pkg::OP_DIV_K1) ? w10_q : w00_q;
    unique case (cmd_i.op)
      ptk_pkg::OP_VDT: begin
        mul_a = ptk_pkg::ext_op(cur_vel);
        mul_b = dt_op;
      end
      ptk_pkg::OP_DTP11: begin
        mul_a = dt_op;
        mul_b = ptk_pkg::ext_op(cur_c11);
      end
      ptk_pkg::OP_DTSUM: begin
        mul_a = dt_op;
        mul_b = ptk_pkg::ext_op(cur_c01) + ptk_pkg::ext_op(cur_c10)
              + ptk_pkg::ext_op(t_q);
      end
      ptk_pkg::OP_K0Y: begin
        mul_a = ptk_pkg::ext_op(k0_q);
        mul_b = y_op;
      end
      ptk_pkg::OP_K1Y: begin
        mul_a = ptk_pkg::ext_op(k1_q);
        mul_b = y_op;
      end
      ptk_pkg::OP_K0P00: begin
        mul_a = ptk_pkg::ext_op(k0_q);
        mul_b = ptk_pkg::ext_op(w00_q);
      end
      ptk_pkg::OP_K0P01: begin
        mul_a = ptk_pkg::ext_op(k0_q);
        mul_b = ptk_pkg::ext_op(w01_q);
      end
      ptk_pkg::OP_K1P00: begin
        mul_a = ptk_pkg::ext_op(k1_q);
        mul_b = ptk_pkg::ext_op(w00_q);
      end
      ptk_pkg::OP_K1P01: begin
        mul_a = ptk_pkg::ext_op(k1_q);
        mul_b = ptk_pkg::ext_op(w01_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ptk_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mres)
  );

  ptk_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (s_den),
    .done_o  (div_done),
    .quo_o   (qres)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      meas_q[0] <= meas_x_i;
      meas_q[1] <= meas_y_i;
      meas_q[2] <= meas_z_i;
      dt_q      <= {step_time_i, 8'd0};
    end
    if (cmd_i.load) begin
      pos_q[axis_i] <= z;
      vel_q[axis_i] <= '0;
      c00_q[axis_i] <= ptk_pkg::sat_st(iv45);
      c01_q[axis_i] <= '0;
      c10_q[axis_i] <= '0;
      c11_q[axis_i] <= ptk_pkg::sat_st(iv45);
    end
    if (div_done) begin
      if (cmd_i.op == ptk_pkg::OP_DIV_K1) begin
        k1_q <= qres;
      end else begin
        k0_q <= qres;
      end
    end
    if (mul_done) begin
      unique case (cmd_i.op)
        ptk_pkg::OP_VDT:
          pp_q <= ptk_pkg::sat_st(ptk_pkg::ext45(cur_pos) + ptk_pkg::ext45(mres));
        ptk_pkg::OP_DTP11:
          t_q <= mres;
        ptk_pkg::OP_DTSUM: begin
          w00_q <= ptk_pkg::sat_st(ptk_pkg::ext45(cur_c00) + ptk_pkg::ext45(mres) + pn45);
          w01_q <= ptk_pkg::sat_st(ptk_pkg::ext45(cur_c01) + ptk_pkg::ext45(t_q));
          w10_q <= ptk_pkg::sat_st(ptk_pkg::ext45(cur_c10) + ptk_pkg::ext45(t_q));
          w11_q <= ptk_pkg::sat_st(ptk_pkg::ext45(cur_c11) + pn45);
          y_q   <= y_d;
        end
        ptk_pkg::OP_K0Y:
          pos_q[axis_i] <= ptk_pkg::sat_st(ptk_pkg::ext45(pp_q) + ptk_pkg::ext45(mres));
        ptk_pkg::OP_K1Y:
          vel_q[axis_i] <= ptk_pkg::sat_st(ptk_pkg::ext45(cur_vel) + ptk_pkg::ext45(mres));
        ptk_pkg::OP_K0P00:
          c00_q[axis_i] <= ptk_pkg::sat_st(ptk_pkg::ext45(w00_q) - ptk_pkg::ext45(mres));
        ptk_pkg::OP_K0P01:
          c01_q[axis_i] <= ptk_pkg::sat_st(ptk_pkg::ext45(w01_q) - ptk_pkg::ext45(mres));
        ptk_pkg::OP_K1P00:
          c10_q[axis_i] <= ptk_pkg::sat_st(ptk_pkg::ext45(w10_q) - ptk_pkg::ext45(mres));
        ptk_pkg::OP_K1P01:
          c11_q[axis_i] <= ptk_pkg::sat_st(ptk_pkg::ext45(w11_q) - ptk_pkg::ext45(mres));
        default: ;
      endcase
    end
  end

  // output register, missing axes read as zero
  for (genvar a = 0; a < 3; a++) begin : g_est
    if (a < AXIS_COUNT) begin : g_used
      always_ff @(posedge clk_i) begin
        if (cmd_i.out_load) begin
          est_q[a] <= ptk_pkg::to_out(pos_q[a]);
        end
      end
    end else begin : g_unused
      always_ff @(posedge clk_i) begin
        if (cmd_i.out_load) begin
          est_q[a] <= '0;
        end
      end
    end
  end

  assign est_o = {est_q[2], est_q[1], est_q[0]};
  assign sts_o = '{mul_done: mul_done, div_done: div_done};

endmodule

// File: sv/ptk_ctrl.sv
// ----------------------------------------------------------------------------
// ptk_ctrl: tracker controller
// Accepts a beat, sequences load or the per-axis update micro-ops through
// the datapath, and hands the result to the output register.
// ----------------------------------------------------------------------------
module ptk_ctrl #(
  parameter int AXIS_COUNT = 3,
  parameter int AXW        = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tuser_i,
  output logic              s_tready_o,
  input  logic              m_tready_i,
  output logic              m_tvalid_o,
  output logic              m_tuser_o,
  input  ptk_pkg::ptk_sts_t sts_i,
  output ptk_pkg::ptk_cmd_t cmd_o,
  output logic [AXW-1:0]    axis_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [AXW-1:0] AxisLast = AXW'(AXIS_COUNT - 1);

  logic [2:0]       state_q, state_d;
  logic [AXW-1:0]   axis_q, axis_d;
  ptk_pkg::op_t     step_q, step_d;
  logic             have_q, have_d;
  logic             valid_q, valid_d;
  logic             ovalid_q, ovalid_d;
  logic             ouser_q, ouser_d;
  logic             is_div, unit_done;

  always_comb begin
    state_d  = state_q;
    axis_d   = axis_q;
    step_d   = step_q;
    have_d   = have_q;
    valid_d  = valid_q;
    ovalid_d = ovalid_q;
    ouser_d  = ouser_q;
    cmd_o    = '0;
    cmd_o.op = step_q;
    is_div    = (step_q == ptk_pkg::OP_DIV_K0) || (step_q == ptk_pkg::OP_DIV_K1);
    unit_done = is_div ? sts_i.div_done : sts_i.mul_done;
    if (ovalid_q && m_tready_i) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          valid_d = s_tuser_i;
          axis_d  = '0;
          step_d  = ptk_pkg::OP_VDT;
          if (!have_q) begin
            state_d = S_LOAD;
          end else if (s_tuser_i) begin
            state_d = S_ISSUE;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        if (axis_q == AxisLast) begin
          have_d  = valid_q;
          state_d = S_DONE;
        end else begin
          axis_d = axis_q + 1'b1;
        end
      end
      S_ISSUE: begin
        cmd_o.mul_start = !is_div;
        cmd_o.div_start = is_div;
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (unit_done) begin
          if (step_q == ptk_pkg::OP_LAST) begin
            step_d = ptk_pkg::OP_VDT;
            if (axis_q == AxisLast) begin
              state_d = S_DONE;
            end else begin
              axis_d  = axis_q + 1'b1;
              state_d = S_ISSUE;
            end
          end else begin
            step_d  = step_q + 4'd1;
            state_d = S_ISSUE;
          end
        end
      end
      S_DONE: begin
        if (!ovalid_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          ovalid_d = 1'b1;
          ouser_d  = have_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      axis_q   <= '0;
      step_q   <= ptk_pkg::OP_VDT;
      have_q   <= 1'b0;
      valid_q  <= 1'b0;
      ovalid_q <= 1'b0;
      ouser_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      axis_q   <= axis_d;
      step_q   <= step_d;
      have_q   <= have_d;
      valid_q  <= valid_d;
      ovalid_q <= ovalid_d;
      ouser_q  <= ouser_d;
    end
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = ovalid_q;
  assign m_tuser_o  = ouser_q;
  assign axis_o     = axis_q;

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts_i.mul_done || sts_i.div_done) |-> (state_q == S_WAIT))
    else $error("arithmetic unit finished outside of wait");
`endif

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for position_kalman_tracker
// Streams 3-axis position samples through the tracker under random valid and
// ready gaps, predicts every estimate with a bit-exact per-axis filter model
// and checks each output beat in order, across several noise settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] pos [3];
    logic [15:0] dt;
    logic        valid;
  } sample_t;

  typedef struct {
    logic [31:0] pos [3];
    logic        valid;
  } estimate_t;

  localparam longint LIM40 = 64'sd549755813887;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_addr_i = '0;
  logic [31:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;  // meas_x, meas_y, meas_z, step_time
  logic         s_axis_tuser = 1'b0;  // sample_valid
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;  // est_x, est_y, est_z
  logic         m_axis_tuser;  // est_valid

  position_kalman_tracker u_dut (.*);

  always #1 clk_i = ~clk_i;

  // tracker model state
  logic [31:0] q_noise = ptk_pkg::PROCESS_NOISE_RST;
  logic [31:0] r_noise = ptk_pkg::MEAS_NOISE_RST;
  logic [31:0] init_var = ptk_pkg::INIT_VAR_RST;
  logic        have_est = 1'b0;
  longint      pos_q [3], vel_q [3], c00 [3], c01 [3], c10 [3], c11 [3];

  sample_t   pending [$];
  estimate_t est_queue [$];
  sample_t   cur_sample;
  int        tx_gap, rx_gap, errors;
  bit        tx_burst, rx_burst;

  function automatic longint sat40(input longint x);
    if (x > LIM40) return LIM40;
    if (x < -LIM40 - 1) return -LIM40 - 1;
    return x;
  endfunction

  // product rounded to 24 fraction bits, half away from zero, saturated
  function automatic longint mul_q24(input longint a, input longint b);
    logic        neg;
    logic [85:0] prod;
    longint      mag;
    neg  = (a < 0) != (b < 0);
    prod = 86'((a < 0) ? -a : a) * 86'((b < 0) ? -b : b);
    prod = (prod + 86'(1 << 23)) >> 24;
    if (neg) begin
      mag = (prod > 86'(LIM40 + 1)) ? LIM40 + 1 : longint'(prod);
      return -mag;
    end
    mag = (prod > 86'(LIM40)) ? LIM40 : longint'(prod);
    return mag;
  endfunction

  function automatic logic [31:0] q24_to_q16(input longint p);
    longint r;
    r = (p + 128) >>> 8;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic void track_axis(input int a, input longint z, input longint dt);
    longint p, v, p00, p01, p10, p11, t, y, s, k0, k1;
    p   = sat40(pos_q[a] + mul_q24(vel_q[a], dt));
    v   = vel_q[a];
    t   = mul_q24(dt, c11[a]);
    p00 = sat40(c00[a] + mul_q24(dt, c01[a] + c10[a] + t) + longint'(q_noise));
    p01 = sat40(c01[a] + t);
    p10 = sat40(c10[a] + t);
    p11 = sat40(c11[a] + longint'(q_noise));
    y   = z - p;
    s   = p00 + longint'(r_noise);
    k0  = 0;
    k1  = 0;
    if (s > 0) begin
      k0 = sat40((p00 * 16777216) / s);
      k1 = sat40((p10 * 16777216) / s);
    end
    pos_q[a] = sat40(p + mul_q24(k0, y));
    vel_q[a] = sat40(v + mul_q24(k1, y));
    c00[a]   = sat40(p00 - mul_q24(k0, p00));
    c01[a]   = sat40(p01 - mul_q24(k0, p01));
    c10[a]   = sat40(p10 - mul_q24(k1, p00));
    c11[a]   = sat40(p11 - mul_q24(k1, p01));
  endfunction

  function automatic void predict_estimate(input sample_t smp);
    estimate_t e;
    longint    z;
    for (int a = 0; a < 3; a++) begin
      z = longint'(signed'(smp.pos[a])) * 256;
      if (!have_est) begin
        pos_q[a] = z;
        vel_q[a] = 0;
        c00[a]   = longint'(init_var);
        c01[a]   = 0;
        c10[a]   = 0;
        c11[a]   = longint'(init_var);
      end else if (smp.valid) begin
        track_axis(a, z, longint'(smp.dt) * 256);
      end
    end
    if (!have_est) have_est = smp.valid;
    for (int a = 0; a < 3; a++) e.pos[a] = q24_to_q16(pos_q[a]);
    e.valid = have_est;
    est_queue.insert(est_queue.size(), e);
  endfunction

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_estimate(cur_sample);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          cur_sample = pending[0];
          pending.delete(0);
          s_axis_tdata <= {cur_sample.dt, cur_sample.pos[2], cur_sample.pos[1],
                           cur_sample.pos[0]};
          s_axis_tuser <= cur_sample.valid;
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 40) == 0) tx_burst = ~tx_burst;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 11);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // estimate monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (est_queue.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected estimate beat %h", m_axis_tdata);
        end else begin
          estimate_t e;
          e = est_queue[0];
          est_queue.delete(0);
          if (m_axis_tdata != {e.pos[2], e.pos[1], e.pos[0]} ||
              m_axis_tuser != e.valid) begin
            errors++;
            if (errors <= 10)
              $display("estimate mismatch: exp %h/%b got %h/%b",
                       {e.pos[2], e.pos[1], e.pos[0]}, e.valid, m_axis_tdata, m_axis_tuser);
          end
        end
        if ($urandom_range(0, 40) == 0) rx_burst = ~rx_burst;
        rx_gap = rx_burst ? 0 : $urandom_range(0, 11);
      end
      if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_noise(input logic [31:0] q, input logic [31:0] r,
                             input logic [31:0] iv);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= ptk_pkg::CFG_PROCESS_NOISE;
    cfg_wdata_i <= q;
    @(posedge clk_i);
    cfg_addr_i <= ptk_pkg::CFG_MEAS_NOISE;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_addr_i <= ptk_pkg::CFG_INIT_VAR;
    cfg_wdata_i <= iv;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    q_noise = q;
    r_noise = r;
    init_var = iv;
  endtask

  task automatic add_sample(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [15:0] dt, input logic v);
    sample_t smp;
    smp.pos[0] = x;
    smp.pos[1] = y;
    smp.pos[2] = z;
    smp.dt = dt;
    smp.valid = v;
    pending.insert(pending.size(), smp);
  endtask

  // sampled on the falling edge so the driver's updates have settled
  task automatic drain();
    do @(negedge clk_i);
    while (pending.size() != 0 || s_axis_tvalid || est_queue.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  // random track: mostly smooth motion with noise, some jumps and full-range values
  task automatic add_track(input int n);
    int pos [3], vel [3];
    for (int a = 0; a < 3; a++) begin
      pos[a] = $urandom_range(0, 1 << 20) - (1 << 19);
      vel[a] = $urandom_range(0, 4096) - 2048;
    end
    for (int i = 0; i < n; i++) begin
      int k;
      k = $urandom_range(0, 19);
      for (int a = 0; a < 3; a++) begin
        pos[a] += vel[a] + int'($urandom_range(0, 1024)) - 512;
        if (k == 0) pos[a] = $urandom;
      end
      add_sample(pos[0], pos[1], pos[2],
                 (k == 1) ? 16'($urandom) : 16'($urandom_range(300, 3000)), k != 2);
    end
  endtask

  initial begin
    #5000000;
    $display("[position_kalman_tracker] ERROR");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: invalid first sample, then load, extremes, holds
    add_sample(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
    add_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 16'h0000, 1'b1);
    add_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 16'hFFFF, 1'b1);
    add_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    add_sample(32'h0, 32'h0, 32'h0, 16'h0, 1'b0);
    add_sample(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 16'h0000, 1'b1);
    add_sample(32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000, 16'h0001, 1'b1);
    add_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 16'h8000, 1'b1);
    add_sample(32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, 16'h7FFF, 1'b1);
    add_sample(32'h0, 32'h0, 32'h0, 16'hFFFF, 1'b0);
    add_track(110);
    drain();
    write_noise(32'h0, 32'h1, 32'h0);
    add_track(100);
    drain();
    write_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_track(100);
    drain();
    write_noise($urandom, $urandom_range(1, 32'hFFFF_FFFF), $urandom);
    add_track(100);
    drain();
    write_noise($urandom_range(0, 1 << 20), $urandom_range(1, 1 << 24), $urandom);
    add_track(100);
    drain();
    write_noise(ptk_pkg::PROCESS_NOISE_RST, ptk_pkg::MEAS_NOISE_RST, ptk_pkg::INIT_VAR_RST);
    add_track(80);
    drain();
    if (errors == 0) begin
      $display("[position_kalman_tracker] OK");
    end else begin
      $display("[position_kalman_tracker] ERROR");
    end
    $finish;
  end

endmodule
